@@ sv/kfpv_pkg.sv @@
// Shared constants for the two-state position/velocity Kalman filter.
// No dependencies; imported by every module of the block.
package kfpv_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Port widths fixed by the interface.
    localparam int FIELD_WIDTH = 32;
    localparam int CFG_WIDTH   = 31;
    localparam int CFG_IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd2;

    // Reset values of the registers, before saturation to the data range.
    localparam int TIME_STEP_RST         = 65536;
    localparam int PROCESS_NOISE_RST     = 66;
    localparam int MEASUREMENT_NOISE_RST = 65536;

    // Bits of the multiplier operand consumed per cycle.
    localparam int DIGIT_BITS = 8;

endpackage

@@ sv/kfpv_mul.sv @@
// Digit-serial signed fixed-point multiplier: rounds half away from zero and saturates.
// Depends on kfpv_pkg.
module kfpv_mul
    import kfpv_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic                done,
    output logic signed [W-1:0] result
);

    localparam int ND = (W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int BW = ND * DIGIT_BITS;
    localparam int PW = 2 * W;
    localparam int CW = $clog2(ND + 1);

    logic [W-1:0]        ua_reg;
    logic [BW-1:0]       ub_reg;
    logic [PW-1:0]       acc_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                neg_reg;
    logic                done_reg;
    logic signed [W-1:0] result_reg;

    logic [W-1:0]            mag_a;
    logic [W-1:0]            mag_b;
    logic [DIGIT_BITS-1:0]   digit;
    logic [W+DIGIT_BITS-1:0] partial;
    logic [PW-1:0]           acc_next;
    logic [PW:0]             rounded;
    logic [PW:0]             mag;
    logic [PW:0]             lim;
    logic [PW:0]             mag_sat;
    logic signed [W-1:0]     signed_res;

    always_comb
    begin
        mag_a    = a[W-1] ? W'(-a) : W'(a);
        mag_b    = b[W-1] ? W'(-b) : W'(b);
        digit    = ub_reg[BW-1 -: DIGIT_BITS];
        partial  = ua_reg * digit;
        acc_next = (acc_reg << DIGIT_BITS) + PW'(partial);
        rounded  = {1'b0, acc_reg} + ((PW+1)'(1) << (F - 1));
        mag      = rounded >> F;
        lim      = ((PW+1)'(1) << (W - 1)) - (neg_reg ? (PW+1)'(0) : (PW+1)'(1));
        mag_sat  = (mag > lim) ? lim : mag;
        signed_res = neg_reg ? -mag_sat[W-1:0] : mag_sat[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(ND);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ua_reg  <= mag_a;
            ub_reg  <= BW'(mag_b);
            acc_reg <= '0;
            neg_reg <= a[W-1] ^ b[W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                acc_reg <= acc_next;
                ub_reg  <= ub_reg << DIGIT_BITS;
            end
            else
            begin
                result_reg <= signed_res;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sv/kfpv_div.sv @@
// Radix-2 restoring divider for the gain: n * 2^F / d with d > 0, truncated, saturated.
// Depends on kfpv_pkg.
module kfpv_div
    import kfpv_pkg::*;
#(
    parameter int W = DATA_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] n,
    input  logic signed [W-1:0] d,
    output logic                done,
    output logic signed [W-1:0] result
);

    localparam int NQ = W + F;
    localparam int CW = $clog2(NQ + 1);

    logic [NQ-1:0]       nd_reg;
    logic [W-1:0]        rem_reg;
    logic [W-1:0]        d_reg;
    logic [NQ-1:0]       q_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                neg_reg;
    logic                done_reg;
    logic signed [W-1:0] result_reg;

    logic [W-1:0]        mag_n;
    logic [W:0]          trial;
    logic                fits;
    logic [NQ-1:0]       lim;
    logic [NQ-1:0]       q_sat;
    logic signed [W-1:0] signed_res;

    always_comb
    begin
        mag_n = n[W-1] ? W'(-n) : W'(n);
        trial = {rem_reg, nd_reg[NQ-1]};
        fits  = trial >= {1'b0, d_reg};
        lim   = (NQ'(1) << (W - 1)) - (neg_reg ? NQ'(0) : NQ'(1));
        q_sat = (q_reg > lim) ? lim : q_reg;
        signed_res = neg_reg ? -q_sat[W-1:0] : q_sat[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NQ);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            nd_reg  <= {mag_n, F'(0)};
            rem_reg <= '0;
            q_reg   <= '0;
            d_reg   <= W'(d);
            neg_reg <= n[W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                // The partial remainder stays below d, so it fits in W bits.
                rem_reg <= fits ? W'(trial - {1'b0, d_reg}) : trial[W-1:0];
                q_reg   <= {q_reg[NQ-2:0], fits};
                nd_reg  <= nd_reg << 1;
            end
            else
            begin
                result_reg <= signed_res;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ sv/kalman_filter_position_velocity.sv @@
// Top level of the two-state constant-velocity Kalman filter on a position sensor.
// Depends on kfpv_pkg, kfpv_mul and kfpv_div.
//
// Each measurement transaction runs one predict/update step on a single shared
// serial multiplier and a serial divider, driven by a small sequencer: nine
// products and two gain divisions, with in_ready low throughout the step. The
// step is longer when the previous result is still waiting to be taken. When the
// innovation variance is not positive the divisions are skipped. The result
// waits in an output register, so the next measurement is taken while it is held.
module kalman_filter_position_velocity
    import kfpv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [FIELD_WIDTH-1:0] measurement,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [FIELD_WIDTH-1:0] position_estimate,
    output logic signed [FIELD_WIDTH-1:0] velocity_estimate
);

    localparam int W  = DATA_WIDTH;
    localparam int XW = ((W > FIELD_WIDTH) ? W : FIELD_WIDTH) + 2;

    localparam logic signed [XW-1:0] VMAX_X = XW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [XW-1:0] VMIN_X = -VMAX_X - XW'(1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_GAIN = 3'd2;
    localparam logic [2:0] ST_DIV0 = 3'd3;
    localparam logic [2:0] ST_DIV1 = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam logic [3:0] MS_XP   = 4'd0;
    localparam logic [3:0] MS_M01  = 4'd1;
    localparam logic [3:0] MS_M00  = 4'd2;
    localparam logic [3:0] MS_PP00 = 4'd3;
    localparam logic [3:0] MS_POS  = 4'd4;
    localparam logic [3:0] MS_VEL  = 4'd5;
    localparam logic [3:0] MS_CP   = 4'd6;
    localparam logic [3:0] MS_CC   = 4'd7;
    localparam logic [3:0] MS_CV   = 4'd8;

    function automatic logic signed [W-1:0] sat(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] c;
        c = (x > VMAX_X) ? VMAX_X : ((x < VMIN_X) ? VMIN_X : x);
        return c[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return sat(XW'(a) + XW'(b));
    endfunction

    function automatic logic signed [W-1:0] ssub(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        return sat(XW'(a) - XW'(b));
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [3:0]          step_reg, step_next;
    logic                mul_issue_reg, mul_issue_next;
    logic                div_issue_reg, div_issue_next;
    logic                out_valid_reg, out_valid_next;

    logic signed [W-1:0] dt_reg, dt_next;
    logic signed [W-1:0] q_reg, q_next;
    logic signed [W-1:0] r_reg, r_next;
    logic signed [W-1:0] pos_reg, pos_next;
    logic signed [W-1:0] vel_reg, vel_next;
    logic signed [W-1:0] cp_reg, cp_next;
    logic signed [W-1:0] cc_reg, cc_next;
    logic signed [W-1:0] cv_reg, cv_next;
    logic signed [W-1:0] z_reg, z_next;
    logic signed [W-1:0] xp_reg, xp_next;
    logic signed [W-1:0] m00_reg, m00_next;
    logic signed [W-1:0] m01_reg, m01_next;
    logic signed [W-1:0] pp00_reg, pp00_next;
    logic signed [W-1:0] pp11_reg, pp11_next;
    logic signed [W-1:0] s_reg, s_next;
    logic signed [W-1:0] innov_reg, innov_next;
    logic signed [W-1:0] k0_reg, k0_next;
    logic signed [W-1:0] k1_reg, k1_next;
    logic signed [FIELD_WIDTH-1:0] pos_out_reg, pos_out_next;
    logic signed [FIELD_WIDTH-1:0] vel_out_reg, vel_out_next;

    logic signed [W-1:0] mul_a;
    logic signed [W-1:0] mul_b;
    logic                mul_done;
    logic signed [W-1:0] mul_res;
    logic signed [W-1:0] div_n;
    logic                div_done;
    logic signed [W-1:0] div_res;
    logic signed [W-1:0] s_calc;
    logic signed [W-1:0] cfg_val;

    kfpv_mul #(.W(W), .F(FRAC_BITS)) u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_issue_reg),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    kfpv_div #(.W(W), .F(FRAC_BITS)) u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_issue_reg),
        .n      (div_n),
        .d      (s_reg),
        .done   (div_done),
        .result (div_res)
    );

    assign div_n   = (state_reg == ST_DIV0) ? pp00_reg : m01_reg;
    assign s_calc  = sadd(pp00_reg, r_reg);
    assign cfg_val = sat(XW'(cfg_data));

    always_comb
    begin
        unique case (step_reg)
            MS_XP:   begin mul_a = dt_reg; mul_b = vel_reg;   end
            MS_M01:  begin mul_a = dt_reg; mul_b = cv_reg;    end
            MS_M00:  begin mul_a = dt_reg; mul_b = cc_reg;    end
            MS_PP00: begin mul_a = dt_reg; mul_b = m01_reg;   end
            MS_POS:  begin mul_a = k0_reg; mul_b = innov_reg; end
            MS_VEL:  begin mul_a = k1_reg; mul_b = innov_reg; end
            MS_CP:   begin mul_a = k0_reg; mul_b = pp00_reg;  end
            MS_CC:   begin mul_a = k0_reg; mul_b = m01_reg;   end
            MS_CV:   begin mul_a = k1_reg; mul_b = m01_reg;   end
            default: begin mul_a = dt_reg; mul_b = vel_reg;   end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        mul_issue_next = 1'b0;
        div_issue_next = 1'b0;
        out_valid_next = out_valid_reg;
        dt_next    = dt_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        pos_next   = pos_reg;
        vel_next   = vel_reg;
        cp_next    = cp_reg;
        cc_next    = cc_reg;
        cv_next    = cv_reg;
        z_next     = z_reg;
        xp_next    = xp_reg;
        m00_next   = m00_reg;
        m01_next   = m01_reg;
        pp00_next  = pp00_reg;
        pp11_next  = pp11_reg;
        s_next     = s_reg;
        innov_next = innov_reg;
        k0_next    = k0_reg;
        k1_next    = k1_reg;
        pos_out_next = pos_out_reg;
        vel_out_next = vel_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_write)
        begin
            if (cfg_index == REG_TIME_STEP)
            begin
                dt_next = cfg_val;
            end
            else if (cfg_index == REG_PROCESS_NOISE)
            begin
                q_next = cfg_val;
            end
            else if (cfg_index == REG_MEASUREMENT_NOISE)
            begin
                r_next = cfg_val;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    z_next         = sat(XW'(measurement));
                    step_next      = MS_XP;
                    mul_issue_next = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    mul_issue_next = 1'b1;
                    step_next      = step_reg + 4'd1;
                    unique case (step_reg)
                        MS_XP:   xp_next  = sadd(pos_reg, mul_res);
                        MS_M01:  m01_next = sadd(cc_reg, mul_res);
                        MS_M00:  m00_next = sadd(cp_reg, mul_res);
                        MS_PP00:
                        begin
                            pp00_next      = sadd(sadd(m00_reg, mul_res), q_reg);
                            pp11_next      = sadd(cv_reg, q_reg);
                            mul_issue_next = 1'b0;
                            state_next     = ST_GAIN;
                        end
                        MS_POS:  pos_next = sadd(xp_reg, mul_res);
                        MS_VEL:  vel_next = sadd(vel_reg, mul_res);
                        MS_CP:   cp_next  = ssub(pp00_reg, mul_res);
                        MS_CC:   cc_next  = ssub(m01_reg, mul_res);
                        MS_CV:
                        begin
                            cv_next        = ssub(pp11_reg, mul_res);
                            mul_issue_next = 1'b0;
                            state_next     = ST_OUT;
                        end
                        default:
                        begin
                            mul_issue_next = 1'b0;
                            state_next     = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_GAIN:
            begin
                s_next     = s_calc;
                innov_next = sat(XW'(z_reg) - XW'(xp_reg));
                step_next  = MS_POS;
                // A non-positive innovation variance gives zero gain.
                if (s_calc <= 0)
                begin
                    k0_next        = '0;
                    k1_next        = '0;
                    mul_issue_next = 1'b1;
                    state_next     = ST_MUL;
                end
                else
                begin
                    div_issue_next = 1'b1;
                    state_next     = ST_DIV0;
                end
            end
            ST_DIV0:
            begin
                if (div_done)
                begin
                    k0_next        = div_res;
                    div_issue_next = 1'b1;
                    state_next     = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    k1_next        = div_res;
                    mul_issue_next = 1'b1;
                    state_next     = ST_MUL;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    pos_out_next   = FIELD_WIDTH'(XW'(pos_reg));
                    vel_out_next   = FIELD_WIDTH'(XW'(vel_reg));
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= MS_XP;
            mul_issue_reg <= 1'b0;
            div_issue_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            dt_reg  <= sat(XW'(TIME_STEP_RST));
            q_reg   <= sat(XW'(PROCESS_NOISE_RST));
            r_reg   <= sat(XW'(MEASUREMENT_NOISE_RST));
            pos_reg <= '0;
            vel_reg <= '0;
            cp_reg  <= sat(XW'(1) << FRAC_BITS);
            cc_reg  <= '0;
            cv_reg  <= sat(XW'(1) << FRAC_BITS);
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            mul_issue_reg <= mul_issue_next;
            div_issue_reg <= div_issue_next;
            out_valid_reg <= out_valid_next;
            dt_reg  <= dt_next;
            q_reg   <= q_next;
            r_reg   <= r_next;
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            cp_reg  <= cp_next;
            cc_reg  <= cc_next;
            cv_reg  <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg       <= z_next;
        xp_reg      <= xp_next;
        m00_reg     <= m00_next;
        m01_reg     <= m01_next;
        pp00_reg    <= pp00_next;
        pp11_reg    <= pp11_next;
        s_reg       <= s_next;
        innov_reg   <= innov_next;
        k0_reg      <= k0_next;
        k1_reg      <= k1_next;
        pos_out_reg <= pos_out_next;
        vel_out_reg <= vel_out_next;
    end

    assign in_ready          = (state_reg == ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign position_estimate = pos_out_reg;
    assign velocity_estimate = vel_out_reg;

endmodule
